@@ rtl/lbc_pkg.sv @@
// Package: shared constants, codes and beat types for the LRU block cache.
`timescale 1ns / 1ps
package lbc_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int BLOCK_WORDS = 32;
  localparam int STAMP_W     = 32;
  localparam int TAG_W       = 12;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W      = $clog2(BLOCK_WORDS);
  localparam int DADDR_W     = IDX_W + WORD_W;
  localparam int TS_W        = TAG_W + STAMP_W;
  localparam int CFG_W       = 13;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_LRD, S_LOUT, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  disk_id;
    logic [7:0]  block_id;
    logic [4:0]  word_index;
    logic [63:0] data_word;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_word_res;
    logic        last;
    logic [31:0] query_count;
    logic [31:0] hit_count;
  } out_beat_t;
endpackage

@@ rtl/lbc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/lru_block_cache.sv @@
// Top level: fully associative block cache with LRU replacement.
`timescale 1ns / 1ps
// Usage
//  - cfg channel: one beat writes entries_in_use (clamped to the entry count).
//    A write re-creates the cache: all entries go invalid and any open write
//    closes. Write only while the block is idle. cfg_ready is always high.
//  - in channel: one beat per request (lookup, insert word, update word).
//    The block takes one request at a time; in_ready is high in idle.
//  - out channel: a lookup hit gives BLOCK_WORDS beats, the final one with
//    last set; every other request gives a single beat with last set.
//  - Sequencing: a request that searches the tags walks the tag/stamp RAM one
//    entry per cycle; words of an open write are written straight from idle.
//    A lookup hit then streams its block word by word, each word read from
//    the data RAM (S_LRD) and then registered for output (S_LOUT).
//  - Output stall: the result sits in an output register until taken; the
//    block holds its sequence meanwhile, but returns to idle and takes the
//    next request once the final beat is in that register.
//  - Reset: all entries invalid, clock and counters zero, cache not created.
module lru_block_cache (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [lbc_pkg::CFG_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lbc_pkg::in_beat_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lbc_pkg::out_beat_t     out_data
);
  localparam int IDX_W   = lbc_pkg::IDX_W;
  localparam int CNT_W   = lbc_pkg::CNT_W;
  localparam int WORD_W  = lbc_pkg::WORD_W;
  localparam int STAMP_W = lbc_pkg::STAMP_W;
  localparam int TAG_W   = lbc_pkg::TAG_W;
  localparam int TS_W    = lbc_pkg::TS_W;
  localparam int DADDR_W = lbc_pkg::DADDR_W;
  localparam int NENT    = lbc_pkg::MAX_ENTRIES;

  // Control state
  lbc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [NENT-1:0]    valid_r, valid_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [31:0]        queries_r, queries_nxt;
  logic [31:0]        hits_r, hits_nxt;
  logic [IDX_W-1:0]   open_slot_r, open_slot_nxt;
  logic               open_write_r, open_write_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Search and sequencing state
  lbc_pkg::in_beat_t  req_r, req_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic               have_r, have_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               tick_r, tick_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  lbc_pkg::out_beat_t out_data_r, out_data_nxt;

  // RAM ports
  logic               ts_we, ts_re;
  logic [IDX_W-1:0]   ts_waddr, ts_raddr;
  logic [TS_W-1:0]    ts_wdata, ts_rdata;
  logic               d_we, d_re;
  logic [DADDR_W-1:0] d_waddr, d_raddr;
  logic [63:0]        d_wdata, d_rdata;

  logic [TAG_W-1:0]   req_tag, ent_tag;
  logic [STAMP_W-1:0] ent_stamp;
  logic               out_free;
  logic               widx_bad;

  lbc_ram #(.WIDTH(TS_W), .DEPTH(NENT)) u_ts_ram (
    .clk, .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
    .re(ts_re), .raddr(ts_raddr), .rdata(ts_rdata)
  );

  lbc_ram #(.WIDTH(64), .DEPTH(NENT * lbc_pkg::BLOCK_WORDS)) u_data_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  assign req_tag   = {req_r.disk_id, req_r.block_id};
  assign ent_tag   = ts_rdata[TS_W-1 -: TAG_W];
  assign ent_stamp = ts_rdata[STAMP_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign widx_bad  = ({1'b0, in_data.word_index} >= 6'(lbc_pkg::BLOCK_WORDS));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == lbc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lbc_pkg::S_IDLE;
      n_r          <= '0;
      valid_r      <= '0;
      clock_r      <= '0;
      queries_r    <= '0;
      hits_r       <= '0;
      open_slot_r  <= '0;
      open_write_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      valid_r      <= valid_nxt;
      clock_r      <= clock_nxt;
      queries_r    <= queries_nxt;
      hits_r       <= hits_nxt;
      open_slot_r  <= open_slot_nxt;
      open_write_r <= open_write_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
    end
  end

  // Payload and sequencing registers need no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    issue_r    <= issue_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_r     <= best_nxt;
    have_r     <= have_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    tick_r     <= tick_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    valid_nxt      = valid_r;
    clock_nxt      = clock_r;
    queries_nxt    = queries_r;
    hits_nxt       = hits_r;
    open_slot_nxt  = open_slot_r;
    open_write_nxt = open_write_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    req_nxt        = req_r;
    issue_nxt      = issue_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    best_nxt       = best_r;
    have_nxt       = have_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    tick_nxt       = tick_r;
    word_nxt       = word_r;
    ts_we          = 1'b0;
    ts_waddr       = slot_r;
    ts_wdata       = {req_tag, clock_r};
    ts_re          = 1'b0;
    ts_raddr       = issue_r[IDX_W-1:0];
    d_we           = 1'b0;
    d_waddr        = {slot_r, {WORD_W{1'b0}}};
    d_wdata        = req_r.data_word;
    d_re           = 1'b0;
    d_raddr        = {slot_r, word_r};

    case (state_r)
      lbc_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          issue_nxt   = '0;
          have_nxt    = 1'b0;
          status_nxt  = lbc_pkg::ST_MISS;
          tick_nxt    = 1'b0;
          state_nxt   = lbc_pkg::S_EMIT;
          case (in_data.action)
            lbc_pkg::ACT_LOOKUP: begin
              open_write_nxt = 1'b0;
              if (n_r != '0 && valid_r[0]) begin
                queries_nxt = queries_r + 32'd1;
                state_nxt   = lbc_pkg::S_SCAN;
              end
            end
            lbc_pkg::ACT_INSERT, lbc_pkg::ACT_UPDATE: begin
              if (in_data.word_index != '0) begin
                if (open_write_r && !widx_bad && ({1'b0, open_slot_r} < n_r)) begin
                  d_we       = 1'b1;
                  d_waddr    = {open_slot_r, in_data.word_index[WORD_W-1:0]};
                  d_wdata    = in_data.data_word;
                  status_nxt = lbc_pkg::ST_OK;
                end
              end else if (n_r == '0) begin
                open_write_nxt = 1'b0;
              end else begin
                state_nxt = lbc_pkg::S_SCAN;
              end
            end
            default: begin
              status_nxt = lbc_pkg::ST_MISS;
            end
          endcase
        end
      end

      lbc_pkg::S_SCAN: begin
        // Issue one tag/stamp read per cycle, compare the one that returns
        if (issue_r < n_r) begin
          ts_re       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (req_r.action == lbc_pkg::ACT_INSERT) begin
            if (!valid_r[cmp_idx_r]) begin
              slot_nxt    = cmp_idx_r;
              tick_nxt    = 1'b1;
              status_nxt  = lbc_pkg::ST_OK;
              cmp_vld_nxt = 1'b0;
              state_nxt   = lbc_pkg::S_APPLY;
            end else if (ent_tag == req_tag) begin
              slot_nxt    = cmp_idx_r;
              tick_nxt    = 1'b0;
              status_nxt  = lbc_pkg::ST_PRESENT;
              cmp_vld_nxt = 1'b0;
              state_nxt   = lbc_pkg::S_APPLY;
            end else if (!have_r || ent_stamp < best_r) begin
              best_nxt = ent_stamp;
              slot_nxt = cmp_idx_r;
              have_nxt = 1'b1;
            end
          end else if (valid_r[cmp_idx_r] && ent_tag == req_tag) begin
            slot_nxt    = cmp_idx_r;
            tick_nxt    = 1'b1;
            status_nxt  = lbc_pkg::ST_OK;
            cmp_vld_nxt = 1'b0;
            state_nxt   = lbc_pkg::S_APPLY;
          end
        end else if (issue_r >= n_r) begin
          // Whole range searched without a decision
          if (req_r.action == lbc_pkg::ACT_INSERT) begin
            tick_nxt   = 1'b1;
            status_nxt = lbc_pkg::ST_OK;
            state_nxt  = lbc_pkg::S_APPLY;
          end else begin
            open_write_nxt = 1'b0;
            status_nxt     = lbc_pkg::ST_MISS;
            state_nxt      = lbc_pkg::S_EMIT;
          end
        end
      end

      lbc_pkg::S_APPLY: begin
        ts_we    = 1'b1;
        ts_wdata = {req_tag, tick_r ? clock_r + 1'b1 : clock_r};
        if (tick_r) begin
          clock_nxt = clock_r + 1'b1;
        end
        if (req_r.action == lbc_pkg::ACT_LOOKUP) begin
          hits_nxt  = hits_r + 32'd1;
          word_nxt  = '0;
          state_nxt = lbc_pkg::S_LRD;
        end else begin
          if (req_r.action == lbc_pkg::ACT_UPDATE) begin
            hits_nxt = hits_r + 32'd1;
          end
          valid_nxt[slot_r] = 1'b1;
          d_we           = 1'b1;
          open_slot_nxt  = slot_r;
          open_write_nxt = 1'b1;
          state_nxt      = lbc_pkg::S_EMIT;
        end
      end

      lbc_pkg::S_LRD: begin
        d_re      = 1'b1;
        state_nxt = lbc_pkg::S_LOUT;
      end

      lbc_pkg::S_LOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: lbc_pkg::ST_OK, data_word_res: d_rdata,
                            last: (word_r == WORD_W'(lbc_pkg::BLOCK_WORDS - 1)),
                            query_count: queries_r, hit_count: hits_r};
          if (word_r == WORD_W'(lbc_pkg::BLOCK_WORDS - 1)) begin
            state_nxt = lbc_pkg::S_IDLE;
          end else begin
            word_nxt  = word_r + 1'b1;
            state_nxt = lbc_pkg::S_LRD;
          end
        end
      end

      lbc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: status_r, data_word_res: 64'd0, last: 1'b1,
                            query_count: queries_r, hit_count: hits_r};
          state_nxt     = lbc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lbc_pkg::S_IDLE;
      end
    endcase

    // Re-create the cache on a register write
    if (cfg_valid) begin
      n_nxt          = (cfg_data > lbc_pkg::CFG_W'(NENT)) ? CNT_W'(NENT)
                                                          : cfg_data[CNT_W-1:0];
      valid_nxt      = '0;
      open_write_nxt = 1'b0;
      open_slot_nxt  = '0;
    end
  end
endmodule

@@ rtl/lbc_checker.sv @@
// Port-level checker for the LRU block cache, bound to the top level.
`timescale 1ns / 1ps
module lbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lbc_pkg::out_beat_t out_data
);
  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // One request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Only a lookup hit streams beats before the last one
  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == lbc_pkg::ST_OK)
    else $error("non-final beat without hit status");
endmodule

bind lru_block_cache lbc_checker u_lbc_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
